[sv/configurable_crc_check_engine_unit_macros.svh]
// assertion macros used by the checker file
`ifndef CONFIGURABLE_CRC_CHECK_ENGINE_UNIT_MACROS_SVH
`define CONFIGURABLE_CRC_CHECK_ENGINE_UNIT_MACROS_SVH

// property checked on every clock edge outside reset
`define CCCE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication checked outside reset
`define CCCE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define CCCE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ccce_pkg.sv]
package ccce_pkg;

    localparam int CFG_INDEX_W = 3;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_WIDTH_SIXTEEN  = 3'd0;
    localparam cfg_index_t REG_POLYNOMIAL     = 3'd1;
    localparam cfg_index_t REG_INITIAL_VALUE  = 3'd2;
    localparam cfg_index_t REG_REFLECT_INPUT  = 3'd3;
    localparam cfg_index_t REG_REFLECT_OUTPUT = 3'd4;
    localparam cfg_index_t REG_FINAL_XOR      = 3'd5;

    localparam logic        RST_WIDTH_SIXTEEN  = 1'b1;
    localparam logic [15:0] RST_POLYNOMIAL     = 16'h1021;
    localparam logic [15:0] RST_INITIAL_VALUE  = 16'hFFFF;
    localparam logic        RST_REFLECT_INPUT  = 1'b1;
    localparam logic        RST_REFLECT_OUTPUT = 1'b1;
    localparam logic [15:0] RST_FINAL_XOR      = 16'h0000;

    localparam logic [15:0] MASK_W16 = 16'hFFFF;
    localparam logic [15:0] MASK_W8  = 16'h00FF;
    localparam logic [15:0] TOP_W16  = 16'h8000;
    localparam logic [15:0] TOP_W8   = 16'h0080;

    localparam logic [1:0] SEEN_MAX = 2'd3;

    function automatic logic [15:0] width_mask(input logic w16);
        return w16 ? MASK_W16 : MASK_W8;
    endfunction

    // bit reverse over 16 or the low 8 bits
    function automatic logic [15:0] rev_width(input logic [15:0] v, input logic w16);
        logic [15:0] r16;
        logic [7:0]  r8;
        for (int i = 0; i < 16; i++)
        begin
            r16[i] = v[15-i];
        end
        for (int i = 0; i < 8; i++)
        begin
            r8[i] = v[7-i];
        end
        return w16 ? r16 : {8'h00, r8};
    endfunction

    // one byte folded into the crc, eight bit steps
    function automatic logic [15:0] crc_fold(
        input logic [15:0] c,
        input logic [7:0]  b,
        input logic        w16,
        input logic [15:0] poly,
        input logic        refin
    );
        logic [15:0] m;
        logic [15:0] p;
        logic [15:0] rp;
        logic [15:0] top;
        logic [15:0] x;
        m   = width_mask(w16);
        p   = poly & m;
        rp  = rev_width(p, w16);
        top = w16 ? TOP_W16 : TOP_W8;
        x   = c & m;
        if (refin)
        begin
            x = x ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
            begin
                x = x[0] ? ((x >> 1) ^ rp) : (x >> 1);
            end
        end
        else
        begin
            x = x ^ (w16 ? {b, 8'h00} : {8'h00, b});
            for (int k = 0; k < 8; k++)
            begin
                x = ((x & top) != 16'h0000) ? (((x << 1) ^ p) & m) : ((x << 1) & m);
            end
        end
        return x & m;
    endfunction

endpackage

[sv/configurable_crc_check_engine_unit.sv]
// Byte-serial CRC-8/CRC-16 engine with configurable polynomial, initial value, input and
// output reflection and final XOR. One byte is accepted per beat, every cycle; the whole
// byte update (eight bit steps of fixed XOR logic) sits between the message state
// registers and the result register, so a result on the last byte of a message appears on
// the master side in the cycle after that byte is accepted.
// While a result waits to be taken the input is held off, except in the cycle in which the
// result is taken, when the next byte enters as well. A message
// starts on a beat with tuser[0] set, which also latches the mode from tuser[1]: calculate
// folds every byte; verify holds back the last one (CRC-8) or two (CRC-16, low byte first)
// bytes as the trailer and compares it with the CRC of the bytes before it. Configuration
// writes are always taken and should be made between messages.
module configurable_crc_check_engine_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // data_byte
    input  logic                          s_tlast,   // last_byte
    input  logic [1:0]                    s_tuser,   // first_byte, op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // crc_value
    output logic [1:0]                    m_tuser,   // match, too_short
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  ccce_pkg::cfg_index_t          cfg_index,
    input  logic [15:0]                   cfg_data
);

    logic        width_sixteen_reg;
    logic [15:0] polynomial_reg;
    logic [15:0] initial_value_reg;
    logic        reflect_input_reg;
    logic        reflect_output_reg;
    logic [15:0] final_xor_reg;

    logic [15:0] crc_reg;
    logic [7:0]  td0_reg;
    logic [7:0]  td1_reg;
    logic [1:0]  seen_reg;
    logic        verify_reg;

    logic [15:0] crc_next;
    logic [7:0]  td0_next;
    logic [7:0]  td1_next;
    logic [1:0]  seen_next;
    logic        verify_next;

    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    logic        in_beat;
    logic        first;
    logic [15:0] mask;
    logic [15:0] crc_cur;
    logic [7:0]  td0_cur;
    logic [7:0]  td1_cur;
    logic [1:0]  seen_cur;
    logic        trailer_full;
    logic        do_fold;
    logic [7:0]  fold_byte;
    logic [15:0] crc_rev;
    logic [15:0] fin;
    logic [15:0] trailer;
    logic        short_msg;
    logic        match;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_beat   = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign first = s_tuser[0];
    assign mask  = ccce_pkg::width_mask(width_sixteen_reg);

    always_comb
    begin
        crc_cur     = first ? (initial_value_reg & mask) : crc_reg;
        td0_cur     = first ? 8'h00 : td0_reg;
        td1_cur     = first ? 8'h00 : td1_reg;
        seen_cur    = first ? 2'd0 : seen_reg;
        verify_next = first ? s_tuser[1] : verify_reg;

        trailer_full = width_sixteen_reg ? (seen_cur >= 2'd2) : (seen_cur >= 2'd1);
        do_fold      = !verify_next || trailer_full;
        fold_byte    = !verify_next ? s_tdata : (width_sixteen_reg ? td1_cur : td0_cur);

        crc_next = do_fold
                 ? ccce_pkg::crc_fold(crc_cur, fold_byte, width_sixteen_reg,
                                      polynomial_reg, reflect_input_reg)
                 : crc_cur;

        if (verify_next)
        begin
            td1_next = td0_cur;
            td0_next = s_tdata;
        end
        else
        begin
            td1_next = td1_cur;
            td0_next = td0_cur;
        end

        seen_next = (seen_cur == ccce_pkg::SEEN_MAX) ? seen_cur : seen_cur + 2'd1;

        crc_rev = crc_next & mask;
        if (reflect_output_reg != reflect_input_reg)
        begin
            crc_rev = ccce_pkg::rev_width(crc_rev, width_sixteen_reg);
        end
        fin = (crc_rev ^ final_xor_reg) & mask;

        trailer   = width_sixteen_reg ? {s_tdata, td0_cur} : {8'h00, s_tdata};
        short_msg = verify_next
                  && (width_sixteen_reg ? (seen_next <= 2'd2) : (seen_next <= 2'd1));
        match     = verify_next && !short_msg && (fin == trailer);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_sixteen_reg  <= ccce_pkg::RST_WIDTH_SIXTEEN;
            polynomial_reg     <= ccce_pkg::RST_POLYNOMIAL;
            initial_value_reg  <= ccce_pkg::RST_INITIAL_VALUE;
            reflect_input_reg  <= ccce_pkg::RST_REFLECT_INPUT;
            reflect_output_reg <= ccce_pkg::RST_REFLECT_OUTPUT;
            final_xor_reg      <= ccce_pkg::RST_FINAL_XOR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ccce_pkg::REG_WIDTH_SIXTEEN:  width_sixteen_reg  <= cfg_data[0];
                ccce_pkg::REG_POLYNOMIAL:     polynomial_reg     <= cfg_data;
                ccce_pkg::REG_INITIAL_VALUE:  initial_value_reg  <= cfg_data;
                ccce_pkg::REG_REFLECT_INPUT:  reflect_input_reg  <= cfg_data[0];
                ccce_pkg::REG_REFLECT_OUTPUT: reflect_output_reg <= cfg_data[0];
                ccce_pkg::REG_FINAL_XOR:      final_xor_reg      <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= 16'h0000;
            td0_reg    <= 8'h00;
            td1_reg    <= 8'h00;
            seen_reg   <= 2'd0;
            verify_reg <= 1'b0;
        end
        else if (in_beat)
        begin
            crc_reg    <= crc_next;
            td0_reg    <= td0_next;
            td1_reg    <= td1_next;
            seen_reg   <= seen_next;
            verify_reg <= verify_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (in_beat && s_tlast)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat && s_tlast)
        begin
            m_tdata_reg <= fin;
            m_tuser_reg <= {short_msg, match};
        end
    end

endmodule

[sv/ccce_checker.sv]
`include "configurable_crc_check_engine_unit_macros.svh"

module ccce_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [1:0]           m_tuser,
    input logic                 cfg_ready
);

    // stalled result beat stays up
    `CCCE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")

    // a new result only follows an accepted last beat
    `CCCE_ASSERT_IMP(a_out_cause, $rose(m_tvalid), $past(s_tvalid && s_tready && s_tlast), "result without last beat")

    // match and too_short exclude each other
    `CCCE_ASSERT_IMP(a_flags, m_tvalid, !(m_tuser[0] && m_tuser[1]), "match with too_short")

    // an empty result register never blocks input
    `CCCE_ASSERT_IMP(a_in_free, !m_tvalid, s_tready, "input stalled with empty output")

    // configuration writes are always taken
    `CCCE_ASSERT(a_cfg_ready, cfg_ready, "configuration write refused")

endmodule

bind configurable_crc_check_engine_unit ccce_checker u_ccce_checker (.*);
